// ===== src/lgb_pkg.sv =====
`timescale 1ns / 1ps
package lgb_pkg;
  localparam int COLUMNS_DEF = 84;
  localparam int ROWS_DEF = 48;
  localparam int ADDR_W = 9;
  localparam int MAX_BYTES = 512;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CUR,
    ST_RD_NEXT,
    ST_CALC,
    ST_WRITE,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;      // start of step: zero up/upp windows, col=0 band=0
    logic rd_cur;     // fetch byte (band, col)
    logic rd_next;    // fetch byte (band, col+1)
    logic calc;       // compute new byte for (band-1, col); also (band, col) on last band
    logic wr_col;     // write back new column entry for band
    logic adv_band;
    logic adv_col;
    logic host_wr;
    logic host_rd;
    logic load_out;
    logic out_done;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_band;
    logic last_col;
  } stat_t;

  // Life rule on one 8-cell byte. up/dn bits are neighbors above row 0 / below row 7.
  function automatic logic [7:0] life_byte(input logic [9:0] l, input logic [9:0] c,
                                           input logic [9:0] r);
    logic [7:0] res;
    logic [3:0] n;
    res = '0;
    for (int k = 0; k < 8; k++) begin
      n = 4'(l[k]) + 4'(l[k+1]) + 4'(l[k+2]) + 4'(c[k]) + 4'(c[k+2])
        + 4'(r[k]) + 4'(r[k+1]) + 4'(r[k+2]);
      res[k] = (n == 4'd3) || (n == 4'd2 && c[k+1]);
    end
    return res;
  endfunction
endpackage

// ===== src/life_generation_bitpacked.sv =====
`timescale 1ns / 1ps
// Write: result valid in the cycle after accept. Read: memory register, then ST_OUT.
// Step: each frame byte is fetched, its right neighbor fetched, computed, written back;
// the step is bound by the single frame memory read port.
// One request in flight; a new one is taken once the controller is idle and the result register is free.
// rst clears control state; frame contents are undefined until written.
module life_generation_bitpacked import lgb_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tuser,   // req_type[1:0]
  input  logic [23:0] s_axis_tdata,  // byte_addr[8:0], wr_data[16:9]
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [15:0] m_axis_tdata   // rd_data[7:0], step_done[8]
);
  cmd_t cmd;
  stat_t stat;
  logic out_load;
  logic [7:0] res_rd, rd_q;
  logic res_done, done_q;

  lgb_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_req(s_axis_tuser[1:0]),
    .in_ready(s_axis_tready), .out_busy(m_axis_tvalid), .out_load, .stat, .cmd
  );

  lgb_dp #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dp (
    .clk, .rst, .cmd, .stat, .byte_addr(s_axis_tdata[8:0]),
    .wr_data(s_axis_tdata[16:9]), .res_rd, .res_done
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    if (out_load) begin
      rd_q <= res_rd;
      done_q <= res_done;
    end
  end
  assign m_axis_tdata = {7'd0, done_q, rd_q};
endmodule

// ===== src/lgb_ctrl.sv =====
`timescale 1ns / 1ps
module lgb_ctrl import lgb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic [1:0] in_req,
  output logic  in_ready,
  input  logic  out_busy,
  output logic  out_load,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !out_busy;
        if (in_valid && !out_busy) begin
          case (req_t'(in_req))
            REQ_STEP: begin
              cmd.clear = 1'b1;
              state_next = ST_RD_CUR;
            end
            REQ_WRITE: begin
              cmd.host_wr = 1'b1;
              cmd.load_out = 1'b1;
              out_load = 1'b1;
            end
            REQ_READ: begin
              cmd.host_rd = 1'b1;
              state_next = ST_OUT;
            end
            default: begin
              cmd.load_out = 1'b1;
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_RD_CUR: begin
        cmd.rd_cur = 1'b1;
        state_next = ST_RD_NEXT;
      end
      ST_RD_NEXT: begin
        cmd.rd_next = 1'b1;
        state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        // band wraps to 0 after the last one so write back starts at the top
        cmd.adv_band = 1'b1;
        if (stat.last_band) state_next = ST_WRITE;
        else state_next = ST_RD_CUR;
      end
      ST_WRITE: begin
        cmd.wr_col = 1'b1;
        if (stat.last_band) begin
          cmd.adv_band = 1'b1;
          cmd.adv_col = 1'b1;
          if (stat.last_col) begin
            cmd.out_done = 1'b1;
            cmd.load_out = 1'b1;
            out_load = 1'b1;
            state_next = ST_IDLE;
          end else state_next = ST_RD_CUR;
        end else cmd.adv_band = 1'b1;
      end
      ST_OUT: begin
        cmd.load_out = 1'b1;
        out_load = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> state == ST_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_RD_CUR |=> state == ST_RD_NEXT)
    else $error("fetch order broken");
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_busy || state != ST_IDLE)
    else $error("result overwrite");
endmodule

// ===== src/lgb_dp.sv =====
`timescale 1ns / 1ps
module lgb_dp import lgb_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output stat_t stat,
  input  logic [ADDR_W-1:0] byte_addr,
  input  logic [7:0] wr_data,
  output logic [7:0] res_rd,
  output logic res_done
);
  localparam int BANDS = ROWS / 8;
  localparam int BYTES = COLUMNS * BANDS;
  localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int CW = $clog2(COLUMNS);
  localparam int AW = $clog2(BYTES);

  logic [7:0] mem [BYTES];
  logic [7:0] old_col [BANDS];
  logic [7:0] new_col [BANDS];
  logic [BW-1:0] band;
  logic [CW-1:0] col;
  logic [7:0] rdq, cur_b, rd_hold;
  logic [7:0] up_l, up_c, up_r; // bands above: prev-gen bytes of band-1
  logic rd_ok;
  logic [AW-1:0] cur_a, rd_a;
  logic [7:0] lb, cb, rb;
  logic has_next_col;
  // pending band (band-1) stored as up_*, its own upper neighbor as upp_*
  logic [7:0] upp_l, upp_c, upp_r;
  logic pend;
  logic [9:0] pl, pc, pr;
  logic [9:0] ql, qc, qr;

  assign cur_a = AW'(band * COLUMNS + col);
  assign has_next_col = (32'(col) < COLUMNS - 1);
  assign stat.last_band = (32'(band) == BANDS - 1);
  assign stat.last_col = (32'(col) == COLUMNS - 1);

  // memory: one read port, one write port
  always_comb begin
    rd_a = cur_a;
    if (cmd.rd_next) rd_a = AW'(cur_a + AW'(1));
    if (cmd.host_rd) rd_a = byte_addr[AW-1:0];
  end
  always_ff @(posedge clk) begin
    if (cmd.rd_cur || cmd.rd_next || cmd.host_rd) rdq <= mem[rd_a];
    if (cmd.host_wr && 32'(byte_addr) < BYTES) mem[byte_addr[AW-1:0]] <= wr_data;
    else if (cmd.wr_col) mem[cur_a] <= new_col[band];
  end

  // fetch window; below band comes from next iteration, so compute one band late
  always_ff @(posedge clk) begin
    if (cmd.rd_next) cur_b <= rdq;
  end
  // rdq in CALC holds next-col byte; cur_b holds cur byte. Use rd_next timing:
  // RD_CUR issues cur read; RD_NEXT captures cur (rdq) and issues next; CALC sees next.

  // previous-gen bytes of the band below are unknown yet; instead compute band b-1
  // when band b fetched. Simpler: keep band b bytes, compute band b-1 at CALC.
  always_comb begin
    lb = (col == '0) ? 8'h00 : old_col[band];
    cb = cur_b;
    rb = has_next_col ? rdq : 8'h00;
  end

  always_comb begin
    pl = {lb[0], up_l, upp_l[7]};
    pc = {cb[0], up_c, upp_c[7]};
    pr = {rb[0], up_r, upp_r[7]};
  end
  // last band has nothing below
  always_comb begin
    ql = {1'b0, lb, up_l[7]};
    qc = {1'b0, cb, up_c[7]};
    qr = {1'b0, rb, up_r[7]};
  end

  always_ff @(posedge clk) begin
    if (rst) pend <= 1'b0;
    else if (cmd.clear || cmd.wr_col && stat.last_band) pend <= 1'b0;
    else if (cmd.calc) pend <= 1'b1;
    if (cmd.clear || (cmd.wr_col && stat.last_band)) begin
      up_l <= 8'h00; up_c <= 8'h00; up_r <= 8'h00;
    end else if (cmd.calc) begin
      if (pend) new_col[BW'(band - BW'(1))] <= life_byte(pl, pc, pr);
      if (stat.last_band) new_col[band] <= life_byte(ql, qc, qr);
      upp_l <= up_l; upp_c <= up_c; upp_r <= up_r;
      up_l <= lb; up_c <= cb; up_r <= rb;
    end
    if (cmd.clear) begin
      upp_l <= 8'h00; upp_c <= 8'h00; upp_r <= 8'h00;
    end
    // old_col[band] was last read as the left neighbor this cycle
    if (cmd.calc) old_col[band] <= cur_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      band <= '0; col <= '0;
    end else begin
      if (cmd.adv_band) band <= stat.last_band ? '0 : BW'(band + BW'(1));
      if (cmd.adv_col) col <= CW'(col + CW'(1));
    end
  end

  always_ff @(posedge clk) rd_ok <= cmd.host_rd && 32'(byte_addr) < BYTES;
  assign rd_hold = rd_ok ? rdq : 8'h00;
  assign res_rd = cmd.out_done ? 8'h00 : (cmd.load_out ? rd_hold : 8'h00);
  assign res_done = cmd.out_done;
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import lgb_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int BANDS = ROWS_DEF / 8;
  localparam int NBYTES = COLS * BANDS;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    req_t kind;
    logic [8:0] addr;
    logic [7:0] data;
  } req_word_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic step_done;
  } resp_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tuser = '0;
  logic [23:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  life_generation_bitpacked dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  req_word_t pending_reqs[$];
  resp_word_t expected_resps[$];
  logic [7:0] frame_img[NBYTES];
  bit written[NBYTES];
  int send_idle_pct = 16;
  int recv_idle_pct = 49;
  bit hold_send = 1'b0;
  bit in_fire = 1'b0;
  int errors = 0;
  int idle_cycles = 0;
  int n_steps = 0, n_reads = 0, n_writes = 0, n_other = 0;

  function automatic bit cell_at(int col, int row, int cur, logic [7:0] prev_col[BANDS]);
    if (col < 0 || col >= COLS || row < 0 || row >= BANDS * 8) return 1'b0;
    if (col == cur - 1) return prev_col[row >> 3][row & 7];
    return frame_img[(row >> 3) * COLS + col][row & 7];
  endfunction

  function automatic void next_generation();
    logic [7:0] prev_col[BANDS];
    logic [7:0] fresh[BANDS];
    int n;
    bit alive;
    foreach (prev_col[b]) prev_col[b] = '0;
    for (int c = 0; c < COLS; c++) begin
      for (int b = 0; b < BANDS; b++) begin
        for (int r = 0; r < 8; r++) begin
          n = 0;
          alive = cell_at(c, b * 8 + r, c, prev_col);
          for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
              if (dx != 0 || dy != 0) n += cell_at(c + dx, b * 8 + r + dy, c, prev_col);
          fresh[b][r] = (n == 3) || (n == 2 && alive);
        end
      end
      for (int b = 0; b < BANDS; b++) begin
        prev_col[b] = frame_img[b * COLS + c];
        frame_img[b * COLS + c] = fresh[b];
      end
    end
  endfunction

  function automatic resp_word_t predict(req_word_t q);
    resp_word_t e;
    e = '0;
    case (q.kind)
      REQ_WRITE: if (q.addr < NBYTES) frame_img[q.addr] = q.data;
      REQ_STEP: begin
        next_generation();
        e.step_done = 1'b1;
      end
      REQ_READ: if (q.addr < NBYTES) e.rd_data = frame_img[q.addr];
      default: ;
    endcase
    return e;
  endfunction

  // Driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_fire) begin
        if (pending_reqs.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          req_word_t q;
          q = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= {6'b0, q.kind};
          s_axis_tdata <= {7'b0, q.data, q.addr};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst) begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        req_word_t q;
        q.kind = req_t'(s_axis_tuser[1:0]);
        q.addr = s_axis_tdata[8:0];
        q.data = s_axis_tdata[16:9];
        expected_resps.push_back(predict(q));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_resps.size() == 0) begin
          $error("unexpected result word %h", m_axis_tdata);
          errors++;
        end else begin
          resp_word_t e;
          e = expected_resps.pop_front();
          if (m_axis_tdata[7:0] !== e.rd_data) begin
            $error("rd_data: expected %h, got %h", e.rd_data, m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tdata[8] !== e.step_done) begin
            $error("step_done: expected %b, got %b", e.step_done, m_axis_tdata[8]);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("** life_generation_bitpacked: FAILED **");
        $finish;
      end
    end
  end

  function automatic void add_req(req_t k, int a, int d);
    req_word_t q;
    q.kind = k;
    q.addr = 9'(a);
    q.data = 8'(d);
    if (k == REQ_WRITE && a < NBYTES) written[a] = 1'b1;
    case (k)
      REQ_WRITE: n_writes++;
      REQ_STEP: n_steps++;
      REQ_READ: n_reads++;
      default: n_other++;
    endcase
    pending_reqs.push_back(q);
  endfunction

  function automatic int written_addr();
    int a;
    do a = $urandom_range(NBYTES - 1); while (!written[a]);
    return a;
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0 || s_axis_tvalid)
      @(posedge clk);
  endtask

  task automatic fill_frame(int density);
    for (int a = 0; a < NBYTES; a++) begin
      int d;
      d = 0;
      for (int k = 0; k < 8; k++) if ($urandom_range(99) < density) d |= 1 << k;
      add_req(REQ_WRITE, a, d);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: blinker at top-left corner, edge cells, out-of-range and unused codes
    add_req(REQ_WRITE, 0, 8'h07);
    add_req(REQ_WRITE, NBYTES - 1, 8'hFF);
    add_req(REQ_WRITE, 511, 8'hAA);
    add_req(REQ_READ, 511, 0);
    add_req(REQ_READ, NBYTES, 0);
    add_req(REQ_NONE, 9'h1FF, 8'hFF);
    add_req(REQ_READ, 0, 0);
    fill_frame(0);
    add_req(REQ_WRITE, 0, 8'h07);
    add_req(REQ_WRITE, COLS - 1, 8'h80);
    add_req(REQ_WRITE, NBYTES - 1, 8'hC0);
    add_req(REQ_WRITE, NBYTES - 2, 8'hC0);
    add_req(REQ_WRITE, COLS + 5, 8'h01);
    add_req(REQ_WRITE, 5, 8'h80);
    add_req(REQ_WRITE, 6, 8'h80);
    add_req(REQ_STEP, 0, 0);
    add_req(REQ_READ, 0, 0);
    add_req(REQ_READ, 1, 0);
    add_req(REQ_READ, NBYTES - 1, 0);
    add_req(REQ_READ, COLS + 5, 0);
    add_req(REQ_STEP, 0, 0);
    add_req(REQ_READ, 5, 0);
    drain();

    // Sender waits for everything to return
    hold_send = 1'b1;
    drain();
    hold_send = 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 16 : 0;
      if (ph != 1) fill_frame(ph == 2 ? 90 : 35);
      for (int i = 0; i < 140; i++) begin
        int pick;
        pick = $urandom_range(99);
        if (pick < 3) add_req(REQ_STEP, $urandom_range(511), $urandom_range(255));
        else if (pick < 40) add_req(REQ_WRITE, $urandom_range(511), $urandom_range(255));
        else if (pick < 90) add_req(REQ_READ, written_addr(), $urandom_range(255));
        else if (pick < 95) add_req(REQ_READ, $urandom_range(NBYTES, 511), 0);
        else add_req(REQ_NONE, $urandom_range(511), $urandom_range(255));
      end
      drain();
    end
    repeat (20) @(posedge clk);

    $display("covered %0d writes, %0d generation steps, %0d reads, %0d unused-code words",
             n_writes, n_steps, n_reads, n_other);
    $display("stall mixes: sender-heavy, receiver-heavy, none; sparse and dense frame reloads");
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("** life_generation_bitpacked: PASSED **");
    end else begin
      $display("** life_generation_bitpacked: FAILED **");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/lgb_pkg.sv
src/lgb_ctrl.sv
src/lgb_dp.sv
src/life_generation_bitpacked.sv
verif/tb_top.sv
